// ----- hdl/stbp_pkg.sv -----
// Shared types, constants and width tables for the symbol-to-byte packer.
package stbp_pkg;

    // Byte and group sizes
    localparam int BYTE_BITS     = 8;
    localparam int MAX_DIMENSION = 7;
    localparam int SYM_BITS      = 5;
    localparam int WORD_BITS     = 40;
    localparam int DIM_BITS      = 3;
    localparam int K_BITS        = 3;
    localparam int CNT_BITS      = 3;
    localparam int NB_BITS       = 3;
    localparam int SHIFT_BITS    = 6;

    // Group queue between front and back
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = 1;
    localparam int QCNT_BITS = 2;

    // Configuration register map (word index)
    localparam logic REG_DIMENSION = 1'b0;
    localparam logic [DIM_BITS-1:0] DIMENSION_RESET = 3'd2;

    // One completed group on its way to the serializer
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [NB_BITS-1:0]   nbytes;
    } group_t;

    // Symbol width k = floor(log2(d*d)), at least 1; dimension 0 handled as 1
    function automatic logic [K_BITS-1:0] sym_width(input logic [DIM_BITS-1:0] dim);
        logic [K_BITS-1:0] k;
        case (dim)
            3'd0:    k = 3'd1;
            3'd1:    k = 3'd1;
            3'd2:    k = 3'd2;
            3'd3:    k = 3'd3;
            3'd4:    k = 3'd4;
            3'd5:    k = 3'd4;
            3'd6:    k = 3'd5;
            3'd7:    k = 3'd5;
            default: k = 3'd1;
        endcase
        return k;
    endfunction

    // Symbols per group: lcm(8,k)/k
    function automatic logic [CNT_BITS:0] group_syms(input logic [K_BITS-1:0] k);
        logic [CNT_BITS:0] n;
        case (k)
            3'd2:    n = 4'd4;
            3'd4:    n = 4'd2;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

    // Bytes per group: lcm(8,k)/8
    function automatic logic [NB_BITS-1:0] group_bytes(input logic [K_BITS-1:0] k);
        logic [NB_BITS-1:0] n;
        case (k)
            3'd3:    n = 3'd3;
            3'd5:    n = 3'd5;
            default: n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

// ----- hdl/stbp_front.sv -----
// Front end: masks each symbol and assembles it into the current group word.
module stbp_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [stbp_pkg::DIM_BITS-1:0] dimension,
    input  logic                          clear,
    input  logic                          push,
    output logic                          full,
    input  logic [stbp_pkg::SYM_BITS-1:0] symbol,
    input  logic                          q_full,
    output logic                          q_push,
    output stbp_pkg::group_t              q_data
);
    import stbp_pkg::*;

    logic [WORD_BITS-1:0]  word_reg, word_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [K_BITS-1:0]     k;
    logic [CNT_BITS:0]     syms;
    logic [CNT_BITS:0]     pos_inc;
    logic                  completes;
    logic                  accept;
    logic [SYM_BITS-1:0]   sym_mask;
    logic [WORD_BITS-1:0]  sym_ext;
    logic [SHIFT_BITS-1:0] shift;
    logic [WORD_BITS-1:0]  word_merged;

    // Group geometry from the dimension
    assign k         = sym_width(dimension);
    assign syms      = group_syms(k);
    assign pos_inc   = {1'b0, count_reg} + 4'd1;
    assign completes = (pos_inc == syms);

    // Stall only when this symbol closes a group and the queue has no room
    assign full   = q_full && completes;
    assign accept = push && !full;

    // Place the masked symbol at offset pos*k
    assign sym_mask    = SYM_BITS'((6'd1 << k) - 6'd1);
    assign sym_ext     = {{(WORD_BITS-SYM_BITS){1'b0}}, symbol & sym_mask};
    assign shift       = SHIFT_BITS'(count_reg) * SHIFT_BITS'(k);
    assign word_merged = word_reg | (sym_ext << shift);

    // Hand the finished group to the queue
    assign q_push      = accept && completes;
    assign q_data.word   = word_merged;
    assign q_data.nbytes = group_bytes(k);

    // Next state
    always_comb
    begin
        word_next  = word_reg;
        count_next = count_reg;
        if (clear)
        begin
            word_next  = '0;
            count_next = '0;
        end
        else if (accept)
        begin
            if (completes)
            begin
                word_next  = '0;
                count_next = '0;
            end
            else
            begin
                word_next  = word_merged;
                count_next = pos_inc[CNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            word_reg  <= word_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/stbp_queue.sv -----
// Two-entry queue of completed groups between front and back.
module stbp_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_push,
    input  stbp_pkg::group_t q_wdata,
    output logic             q_full,
    input  logic             q_pop,
    output logic             q_empty,
    output stbp_pkg::group_t q_head
);
    import stbp_pkg::*;

    group_t                mem [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == QCNT_BITS'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign q_head  = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (q_push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!q_push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            mem[wr_ptr_reg] <= q_wdata;
        end
    end

endmodule

// ----- hdl/stbp_back.sv -----
// Back end: serializes each group into bytes, most significant first.
module stbp_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  stbp_pkg::group_t               q_head,
    output logic                           q_pop,
    output logic                           empty,
    input  logic                           pop,
    output logic [stbp_pkg::BYTE_BITS-1:0] data_byte,
    output logic                           group_last
);
    import stbp_pkg::*;

    logic [NB_BITS-1:0]   idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    logic [BYTE_BITS-1:0] byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic                 load;
    logic                 is_last;
    logic [NB_BITS-1:0]   sel;

    // Byte position counted from the low end of the word
    assign sel     = q_head.nbytes - 3'd1 - idx_reg;
    assign is_last = (idx_reg == q_head.nbytes - 3'd1);

    // Refill the output register whenever it is free or being taken
    assign load  = !q_empty && (!valid_reg || pop);
    assign q_pop = load && is_last;

    assign empty      = !valid_reg;
    assign data_byte  = byte_reg;
    assign group_last = last_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = q_head.word[{sel, 3'b000} +: BYTE_BITS];
            last_next  = is_last;
            idx_next   = is_last ? '0 : idx_reg + 3'd1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule

// ----- hdl/symbol_to_byte_packer_core.sv -----
// Symbol-to-byte packer: k-bit symbols in, packed bytes out.
//
// Input channel: push/full with symbol (low k bits used, k set by dimension).
// Output channel: empty/pop with data_byte and group_last; the oldest byte is
// shown while empty is low and is taken on pop.
// A group of lcm(8,k)/k symbols yields lcm(8,k)/8 bytes, most significant byte
// first; group_last marks the final byte of each group.
// Throughput: one symbol per cycle while full is low, one byte per cycle while
// pop is high and empty is low. The first byte of a group passes through the
// group queue and then the output register when that register is free or taken.
// A two-entry group queue sits between the symbol assembler and the byte
// serializer; full rises only when a closing symbol meets a full queue. A
// group stays queued until its last byte loads the output register, so a
// stalled receiver backs up into the input once two groups wait (one of them
// partly shown) and a third one closes.
// Configuration: APB register 0 at address 0 holds dimension (reset 2).
// Writing it discards any partial group. pready is always high.
// Reset (rst_n low) empties the queue and output and starts a fresh group.
module symbol_to_byte_packer_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Symbol input
    input  logic                           push,
    output logic                           full,
    input  logic [stbp_pkg::SYM_BITS-1:0]  symbol,
    // Byte output
    output logic                           empty,
    input  logic                           pop,
    output logic [stbp_pkg::BYTE_BITS-1:0] data_byte,
    output logic                           group_last
);
    import stbp_pkg::*;

    logic [DIM_BITS-1:0] dimension_reg, dimension_next;
    logic                cfg_we;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    group_t              q_wdata;
    group_t              q_head;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_DIMENSION);
    assign prdata = (paddr[2] == REG_DIMENSION) ? {29'b0, dimension_reg} : 32'b0;

    always_comb
    begin
        dimension_next = dimension_reg;
        if (cfg_we)
        begin
            dimension_next = pwdata[DIM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= DIMENSION_RESET;
        end
        else
        begin
            dimension_reg <= dimension_next;
        end
    end

    // Symbol assembler
    stbp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dimension (dimension_reg),
        .clear     (cfg_we),
        .push      (push),
        .full      (full),
        .symbol    (symbol),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    // Group queue
    stbp_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_head  (q_head)
    );

    // Byte serializer
    stbp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .data_byte  (data_byte),
        .group_last (group_last)
    );

endmodule

// ----- verif/symbol_to_byte_packer_core_test.sv -----
`timescale 1ns / 1ps
// Testbench for symbol_to_byte_packer_core: directed and random symbol streams.
module symbol_to_byte_packer_core_test;
    import stbp_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 200;
    localparam int HOLD_CYCLES   = 120;

    // Register map: one word per register
    localparam logic [2:0] ADDR_DIMENSION = {REG_DIMENSION, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED  = {~REG_DIMENSION, 2'b00};

    typedef struct {
        logic [BYTE_BITS-1:0] data;
        logic                 last;
    } packed_byte_t;

    // DUT inputs, known from time zero
    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [2:0]           paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic                 push    = 1'b0;
    logic [SYM_BITS-1:0]  symbol  = '0;
    logic                 pop     = 1'b0;

    // DUT outputs
    logic [31:0]          prdata;
    logic                 pready;
    logic                 full;
    logic                 empty;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 group_last;

    // Packing predictor state
    logic [DIM_BITS-1:0]  dim_setting = DIMENSION_RESET;
    logic [WORD_BITS-1:0] group_bits  = '0;
    int unsigned          group_fill  = 0;
    packed_byte_t         expected_bytes[$];

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned send_run    = 0;
    int unsigned take_run    = 0;
    int unsigned hold_request = 0;
    bit          sender_rush = 1'b0;

    symbol_to_byte_packer_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .symbol     (symbol),
        .empty      (empty),
        .pop        (pop),
        .data_byte  (data_byte),
        .group_last (group_last)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Symbol width: floor(log2(d*d)), at least 1; dimension 0 runs as 1
    function automatic int unsigned width_for(logic [DIM_BITS-1:0] dim);
        int unsigned d;
        int unsigned k;
        d = (dim == 0) ? 1 : dim;
        if (d > MAX_DIMENSION)
            d = MAX_DIMENSION;
        if (d == 1)
            return 1;
        k = 0;
        while ((1 << (k + 1)) <= d * d)
            k++;
        return k;
    endfunction

    // Bits per group: lcm(8, k)
    function automatic int unsigned span_for(int unsigned k);
        int unsigned a;
        int unsigned b;
        int unsigned t;
        a = BYTE_BITS;
        b = k;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return (BYTE_BITS * k) / a;
    endfunction

    // Add one accepted symbol; queue the group's bytes once it closes
    function automatic void pack_symbol(logic [SYM_BITS-1:0] sym);
        int unsigned  k;
        int unsigned  span;
        int unsigned  nbytes;
        int unsigned  i;
        packed_byte_t b;
        k      = width_for(dim_setting);
        span   = span_for(k);
        nbytes = span / BYTE_BITS;
        group_bits = group_bits
                   | (WORD_BITS'(sym & SYM_BITS'((1 << k) - 1)) << (group_fill * k));
        group_fill++;
        if (group_fill < span / k)
            return;
        for (i = 0; i < nbytes; i++)
        begin
            b.data = 8'(group_bits >> ((nbytes - 1 - i) * BYTE_BITS));
            b.last = (i == nbytes - 1);
            expected_bytes.push_back(b);
        end
        group_bits = '0;
        group_fill = 0;
    endfunction

    // Idle cycles before the next transaction, with occasional runs of none
    function automatic int unsigned draw_gap(inout int unsigned run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            run_left = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Byte checker: every popped transaction against the oldest expected byte
    always @(posedge clk)
    begin
        packed_byte_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                          data_byte, group_last));
            else
            begin
                want = expected_bytes.pop_front();
                if (data_byte !== want.data)
                    report_mismatch($sformatf("data_byte %02h, expected %02h",
                                              data_byte, want.data));
                if (group_last !== want.last)
                    report_mismatch($sformatf("group_last %0b, expected %0b on byte %02h",
                                              group_last, want.last, want.data));
            end
        end
    end

    // Byte receiver: random pop gaps plus the long hold-off on request
    initial
    begin : receiver
        int unsigned gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                pop = 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end
            gap = draw_gap(take_run);
            if (gap > 0)
            begin
                pop = 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop = 1'b1;
            do @(posedge clk); while (empty);
            @(negedge clk);
        end
    end

    // One symbol transaction; called and returns at a falling edge
    task automatic send_symbol(logic [SYM_BITS-1:0] sym);
        int unsigned gap;
        gap = sender_rush ? 0 : draw_gap(send_run);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push   = 1'b1;
        symbol = sym;
        do @(posedge clk); while (full);
        pack_symbol(sym);
        @(negedge clk);
    endtask

    // Stop sending and let every expected byte come out
    task automatic wait_idle();
        push = 1'b0;
        while (expected_bytes.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        // A dimension write restarts the group; other addresses change nothing
        if (addr == ADDR_DIMENSION)
        begin
            dim_setting = value[DIM_BITS-1:0];
            group_bits  = '0;
            group_fill  = 0;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_dimension();
        logic [31:0] value;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_DIMENSION;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        value = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (value !== 32'(dim_setting))
            report_mismatch($sformatf("dimension reads %0h, expected %0d", value, dim_setting));
    endtask

    // Upper write data bits are random: only the low three bits are kept
    task automatic set_dimension(logic [DIM_BITS-1:0] dim);
        wait_idle();
        write_register(ADDR_DIMENSION, {(32 - DIM_BITS)'($urandom() >> DIM_BITS), dim});
        check_dimension();
    endtask

    // Reset dimension (k=2): one group of extreme symbols, high bits masked
    task automatic test_reset_width();
        send_symbol(5'd31);
        send_symbol(5'd0);
        send_symbol(5'd31);
        send_symbol(5'd0);
    endtask

    // Dimension zero packs single bits like dimension one
    task automatic test_dimension_zero();
        set_dimension(3'd0);
        repeat (4)
        begin
            send_symbol(5'b11110);
            send_symbol(5'b00001);
        end
    endtask

    // Dimension 7 (k=5): five bytes per group, all ones
    task automatic test_widest_symbols();
        set_dimension(3'd7);
        repeat (8) send_symbol(5'd31);
    endtask

    // A dimension write drops the half-built group
    task automatic test_partial_group_discard();
        set_dimension(3'd4);
        send_symbol(5'h1F);
        set_dimension(3'd5);
        send_symbol(5'h03);
        send_symbol(5'h1C);
    endtask

    // A write to an unmapped address keeps the group and the dimension
    task automatic test_unmapped_register();
        send_symbol(5'h0A);
        wait_idle();
        write_register(ADDR_UNMAPPED, $urandom());
        check_dimension();
        send_symbol(5'h15);
    endtask

    // Receiver holds off while symbols keep coming: queue fills, full rises
    task automatic test_backpressure_fill();
        set_dimension(3'd6);
        sender_rush  = 1'b1;
        hold_request = HOLD_CYCLES;
        repeat (48) send_symbol($urandom_range(0, 31));
        sender_rush = 1'b0;
        wait_idle();
    endtask

    // Random symbol streams over a series of dimension settings
    task automatic test_random_streams();
        int unsigned         sent;
        int unsigned         n;
        int unsigned         phase;
        logic [DIM_BITS-1:0] dim;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase)
                0:       dim = 3'd0;
                1:       dim = 3'd7;
                2:       dim = 3'd3;
                3:       dim = 3'd1;
                default: dim = $urandom_range(0, 7);
            endcase
            set_dimension(dim);
            n = $urandom_range(6, 40);
            repeat (n) send_symbol($urandom_range(0, 31));
            sent += n;
            phase++;
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_width();
        test_dimension_zero();
        test_widest_symbols();
        test_partial_group_discard();
        test_unmapped_register();
        test_backpressure_fill();
        test_random_streams();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d bytes outstanding",
                 cycle_count, expected_bytes.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
